// ----- hw/rtl/tpp_pkg.sv -----
// Package for the turtle pen plotter: grid constants, command codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package tpp_pkg;

  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int ROW_W     = 64;
  localparam int DIST_W    = 7;

  localparam logic [COORD_W-1:0] LAST_COORD = COORD_W'(GRID_SIZE - 1);

  typedef enum logic [2:0] {
    ACT_PEN_UP   = 3'd0,
    ACT_PEN_DOWN = 3'd1,
    ACT_TURN_R   = 3'd2,
    ACT_TURN_L   = 3'd3,
    ACT_MOVE     = 3'd4,
    ACT_DUMP     = 3'd5,
    ACT_HALT     = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SWEEP,
    S_DRAIN,
    S_DUMP,
    S_DUMP_WAIT
  } state_t;

  typedef struct packed {
    logic pen_up;
    logic pen_down;
    logic turn_r;
    logic turn_l;
    logic halt;
    logic load;
    logic setup;
    logic sweep_rd;
    logic dump_start;
    logic dump_rd;
  } tpp_cmd_t;

  typedef struct packed {
    logic stopped;
    logic skip;
    logic sweep_last;
    logic dump_last;
    logic can_issue;
    logic dump_busy;
  } tpp_status_t;

endpackage

// ----- hw/rtl/tpp_in_if.sv -----
// Command channel interface: valid/ready handshake carrying action and distance.
// Depends on tpp_pkg for field widths.
interface tpp_in_if import tpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output action, output distance, input ready);
  modport sink   (input valid, input action, input distance, output ready);
endinterface

// ----- hw/rtl/tpp_out_if.sv -----
// Row channel interface: valid/ready handshake carrying one dumped bitmap row.
// Depends on tpp_pkg for field widths.
interface tpp_out_if import tpp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row_index;
  logic [ROW_W-1:0]   row_bits;
  logic               last_row;

  modport source (output valid, output row_index, output row_bits, output last_row, input ready);
  modport sink   (input valid, input row_index, input row_bits, input last_row, output ready);
endinterface

// ----- hw/rtl/tpp_ctrl.sv -----
// Controller state machine of the turtle pen plotter: decodes commands and
// sequences move sweeps and dumps. Depends on tpp_pkg.
module tpp_ctrl import tpp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [2:0]  action,
  output logic        in_ready,
  input  tpp_status_t status,
  output tpp_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && (state == S_IDLE) && !status.stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && action == ACT_MOVE) begin
          state_next = S_SETUP;
        end else if (accept && action == ACT_DUMP) begin
          state_next = S_DUMP;
        end
      end
      S_SETUP: begin
        state_next = status.skip ? S_IDLE : S_SWEEP;
      end
      S_SWEEP: begin
        if (status.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_IDLE;
      end
      S_DUMP: begin
        if (status.can_issue && status.dump_last) begin
          state_next = S_DUMP_WAIT;
        end
      end
      S_DUMP_WAIT: begin
        if (!status.dump_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_PEN_UP:   cmd.pen_up     = 1'b1;
            ACT_PEN_DOWN: cmd.pen_down   = 1'b1;
            ACT_TURN_R:   cmd.turn_r     = 1'b1;
            ACT_TURN_L:   cmd.turn_l     = 1'b1;
            ACT_MOVE:     cmd.load       = 1'b1;
            ACT_DUMP:     cmd.dump_start = 1'b1;
            ACT_HALT:     cmd.halt       = 1'b1;
            default:      cmd            = '0;
          endcase
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
      end
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
      end
      S_DUMP: begin
        cmd.dump_rd = status.can_issue;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tpp_datapath.sv -----
// Datapath of the turtle pen plotter: canvas memory with per-row valid bits,
// turtle position and heading, row sweep counter and output register. Depends on tpp_pkg.
module tpp_datapath import tpp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [DIST_W-1:0]  distance,
  input  tpp_cmd_t           cmd,
  output tpp_status_t        status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] row_index,
  output logic [ROW_W-1:0]   row_bits,
  output logic               last_row
);

  logic [ROW_W-1:0]   canvas_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] row_valid;

  logic [COORD_W-1:0] cur_row;
  logic [COORD_W-1:0] cur_col;
  logic [1:0]         heading;
  logic               pen_lifted;
  logic               stopped;
  logic [DIST_W-1:0]  dist_q;

  logic [COORD_W-1:0] row_ptr;
  logic [COORD_W-1:0] sweep_hi;
  logic [ROW_W-1:0]   mask;
  logic               mark_pend;
  logic [COORD_W-1:0] pend_row;
  logic               dump_pend;
  logic [COORD_W-1:0] dump_row;
  logic [ROW_W-1:0]   mem_q;
  logic               mem_q_vld;

  logic [ROW_W-1:0]   eff_row;
  logic               rd_en;
  logic               out_free;
  logic               out_load;

  logic [DIST_W-1:0]  span;
  logic [COORD_W-1:0] row_fwd;
  logic [COORD_W-1:0] row_back;
  logic [COORD_W-1:0] col_fwd;
  logic [COORD_W-1:0] col_back;
  logic [COORD_W-1:0] row_next;
  logic [COORD_W-1:0] col_next;
  logic [COORD_W-1:0] lo_next;
  logic [COORD_W-1:0] hi_next;
  logic [ROW_W-1:0]   mask_next;

  function automatic logic [COORD_W-1:0] step_fwd(input logic [COORD_W-1:0] p,
                                                  input logic [DIST_W-1:0] s);
    logic [COORD_W-1:0] room;
    room = LAST_COORD - p;
    if (s > {1'b0, room}) begin
      step_fwd = LAST_COORD;
    end else begin
      step_fwd = p + s[COORD_W-1:0];
    end
  endfunction

  function automatic logic [COORD_W-1:0] step_back(input logic [COORD_W-1:0] p,
                                                   input logic [DIST_W-1:0] s);
    if (s > {1'b0, p}) begin
      step_back = '0;
    end else begin
      step_back = p - s[COORD_W-1:0];
    end
  endfunction

  function automatic logic [ROW_W-1:0] span_mask(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    span_mask = ({ROW_W{1'b1}} << a) & ({ROW_W{1'b1}} >> (COORD_W'(ROW_W - 1) - b));
  endfunction

  assign span     = dist_q - DIST_W'(1);
  assign row_fwd  = step_fwd(cur_row, span);
  assign row_back = step_back(cur_row, span);
  assign col_fwd  = step_fwd(cur_col, span);
  assign col_back = step_back(cur_col, span);

  always_comb begin
    row_next  = cur_row;
    col_next  = cur_col;
    lo_next   = cur_row;
    hi_next   = cur_row;
    mask_next = ROW_W'(1) << cur_col;
    case (heading)
      HEAD_UP: begin
        row_next = row_back;
        lo_next  = row_back;
      end
      HEAD_RIGHT: begin
        col_next  = col_fwd;
        mask_next = span_mask(cur_col, col_fwd);
      end
      HEAD_DOWN: begin
        row_next = row_fwd;
        hi_next  = row_fwd;
      end
      default: begin
        col_next  = col_back;
        mask_next = span_mask(col_back, cur_col);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      heading    <= HEAD_RIGHT;
      pen_lifted <= 1'b1;
      stopped    <= 1'b0;
    end else begin
      if (cmd.pen_up) begin
        pen_lifted <= 1'b1;
      end
      if (cmd.pen_down) begin
        pen_lifted <= 1'b0;
      end
      if (cmd.turn_r) begin
        heading <= heading + 2'd1;
      end
      if (cmd.turn_l) begin
        heading <= heading - 2'd1;
      end
      if (cmd.halt) begin
        stopped <= 1'b1;
      end
      if (cmd.setup && dist_q != '0) begin
        cur_row <= row_next;
        cur_col <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dist_q <= distance;
    end
    if (cmd.setup) begin
      sweep_hi <= hi_next;
      mask     <= mask_next;
    end
    if (cmd.setup) begin
      row_ptr <= lo_next;
    end else if (cmd.dump_start) begin
      row_ptr <= '0;
    end else if (rd_en) begin
      row_ptr <= row_ptr + COORD_W'(1);
    end
    pend_row <= row_ptr;
    if (cmd.dump_rd) begin
      dump_row <= row_ptr;
    end
  end

  assign rd_en   = cmd.sweep_rd || cmd.dump_rd;
  assign eff_row = mem_q_vld ? mem_q : '0;

  always_ff @(posedge clk) begin
    if (mark_pend) begin
      canvas_mem[pend_row] <= eff_row | mask;
    end
    if (rd_en) begin
      mem_q <= canvas_mem[row_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mark_pend) begin
      row_valid[pend_row] <= 1'b1;
    end
    if (rd_en) begin
      mem_q_vld <= row_valid[row_ptr];
    end
  end

  assign out_free = !out_valid || out_ready;
  assign out_load = dump_pend && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_pend <= 1'b0;
      dump_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mark_pend <= cmd.sweep_rd;
      if (cmd.dump_rd) begin
        dump_pend <= 1'b1;
      end else if (out_load) begin
        dump_pend <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_index <= dump_row;
      row_bits  <= eff_row;
      last_row  <= (dump_row == LAST_COORD);
    end
  end

  always_comb begin
    status            = '0;
    status.stopped    = stopped;
    status.skip       = pen_lifted || (dist_q == '0);
    status.sweep_last = (row_ptr == sweep_hi);
    status.dump_last  = (row_ptr == LAST_COORD);
    status.can_issue  = !dump_pend || out_free;
    status.dump_busy  = dump_pend;
  end

endmodule

// ----- hw/rtl/turtle_pen_plotter_top.sv -----
// Top level of the turtle pen plotter: joins the controller and the datapath.
// Depends on tpp_pkg, tpp_in_if, tpp_out_if, tpp_ctrl and tpp_datapath.
//
// Usage: turtle commands enter on the cmd channel (action, distance); a dump
// returns the bitmap on the rows channel as GRID_SIZE transactions, top row
// first, with last_row set on the final one. Other commands return nothing.
// Pen, turn and halt commands are done in the idle state. A move with the pen
// up or a distance of zero skips the sweep; with the pen down it sweeps one row
// for a horizontal move and each covered row for a vertical one, then drains.
// A dump reads every row in turn. Both are paced by the canvas memory, which
// is read and written one row per cycle, while the receiver keeps ready high
// during a dump, through a single read port and a single write port.
// Reset clears the canvas, homes the turtle to the top left cell facing right
// with the pen up, and clears the halt. When the receiver stalls, the dump
// holds one row in the output register and one in the memory read register;
// the block takes the next command once the last row has moved into the output
// register and the controller has left its dump wait state. After a halt every
// command is taken and ignored until reset.
module turtle_pen_plotter_top import tpp_pkg::*; (
  input logic        clk,
  input logic        rst,
  tpp_in_if.sink     cmd,
  tpp_out_if.source  rows
);

  tpp_cmd_t    ctrl_cmd;
  tpp_status_t dp_status;

  tpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .action   (cmd.action),
    .in_ready (cmd.ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  tpp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .distance  (cmd.distance),
    .cmd       (ctrl_cmd),
    .status    (dp_status),
    .out_valid (rows.valid),
    .out_ready (rows.ready),
    .row_index (rows.row_index),
    .row_bits  (rows.row_bits),
    .last_row  (rows.last_row)
  );

endmodule

// ----- hw/rtl/tpp_checker.sv -----
// Port-level checker for the turtle pen plotter, bound to the top level.
// Depends on tpp_pkg and turtle_pen_plotter_top.
module tpp_checker import tpp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] row_index,
  input logic               last_row
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_index) && $stable(last_row))
    else $error("output transaction changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == LAST_COORD)))
    else $error("last_row does not match the final row index");

endmodule

bind turtle_pen_plotter_top tpp_checker u_tpp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (rows.valid),
  .out_ready (rows.ready),
  .row_index (rows.row_index),
  .last_row  (rows.last_row)
);
